// ===== hw/rtl/cpr_pkg.sv =====
`default_nettype none

package cpr_pkg;

    localparam int VAL_W     = 32;
    localparam int XW        = 40;
    localparam int PW        = 72;
    localparam int SQ_IN_W   = 68;
    localparam int SQ_STEPS  = 34;
    localparam int SQ_REM_W  = 36;
    localparam int DIV_NUM_W = 64;
    localparam int DIV_DEN_W = 34;
    localparam int DIV_Q_W   = 31;
    localparam int DIV_REM_W = 34;
    localparam int IMP_STAGES = 8;
    localparam logic signed [31:0] ONE_PLUS_E_Q30 = 32'sd1717986918;

    typedef struct packed {
        logic signed [31:0] a_pos_x;
        logic signed [31:0] a_pos_y;
        logic signed [31:0] a_vel_x;
        logic signed [31:0] a_vel_y;
        logic [31:0]        a_diameter;
        logic [31:0]        a_mass;
        logic signed [31:0] b_pos_x;
        logic signed [31:0] b_pos_y;
        logic signed [31:0] b_vel_x;
        logic signed [31:0] b_vel_y;
        logic [31:0]        b_diameter;
        logic [31:0]        b_mass;
    } t_in;

    typedef struct packed {
        logic signed [31:0] new_a_pos_x;
        logic signed [31:0] new_a_pos_y;
        logic signed [31:0] new_a_vel_x;
        logic signed [31:0] new_a_vel_y;
        logic signed [31:0] new_b_pos_x;
        logic signed [31:0] new_b_pos_y;
        logic signed [31:0] new_b_vel_x;
        logic signed [31:0] new_b_vel_y;
        logic               hit;
        logic               impulse_applied;
    } t_out;

    typedef struct packed {
        t_in                orig;
        logic               sx;
        logic               sy;
        logic [32:0]        mdx;
        logic [32:0]        mdy;
        logic [32:0]        s;
        logic signed [32:0] rvx;
        logic signed [32:0] rvy;
        logic [32:0]        msum;
        logic [63:0]        wnum_a;
        logic [63:0]        wnum_b;
        logic               hit;
        logic               nz;
    } t_side_a;

    typedef struct packed {
        t_in                orig;
        logic               sx;
        logic               sy;
        logic signed [32:0] rvx;
        logic signed [32:0] rvy;
        logic               msum_z;
        logic               hit;
        logic               ok;
        logic [33:0]        ovp;
    } t_side_b;

    typedef struct packed {
        t_in                orig;
        logic               hit;
        logic               ok;
        logic [33:0]        ovp;
        logic signed [32:0] rvx;
        logic signed [32:0] rvy;
        logic signed [31:0] nx;
        logic signed [31:0] ny;
        logic [30:0]        wa;
        logic [30:0]        wb;
    } t_imp;

    typedef struct packed {
        t_in                orig;
        logic               hit;
        logic               imp;
        logic signed [31:0] nx;
        logic signed [31:0] ny;
        logic [30:0]        wa;
        logic [30:0]        wb;
    } t_ctx;

    function automatic logic signed [PW-1:0] smul(input logic signed [XW-1:0] a,
                                                  input logic signed [31:0] b);
        return PW'(a) * PW'(b);
    endfunction

    // Shift right by k with the magnitude rounded half away from zero.
    function automatic logic signed [XW-1:0] rshr(input logic signed [PW-1:0] p,
                                                  input int unsigned k);
        logic signed [PW-1:0] t;
        t = p + (PW'(1) << (k - 1)) - PW'(p[PW-1]);
        return XW'(t >>> k);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [XW-1:0] v);
        logic signed [31:0] r;
        if (v > 40'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -40'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/circle_pair_collision_resolver.sv =====
`default_nettype none

// Channel  | Direction | Transfer when        | Payload
// ---------+-----------+----------------------+-------------------------
// item     | in        | start && !busy       | i_item   (cpr_pkg::t_in)
// result   | out       | o_valid (one cycle)  | o_result (cpr_pkg::t_out)
//
// busy stays low, so one body pair is taken in every cycle.
// The delay from the transfer edge of a pair to its result strobe is set mostly
// by the 34 square root steps and the 31 divider steps, one bit per stage.
// Reset is synchronous and clears only the valid bits of the stages.
// Results cannot be held off and leave on the strobe in transfer order.

module circle_pair_collision_resolver (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           start,
    input  wire cpr_pkg::t_in   i_item,
    output logic                busy,
    output logic                o_valid,
    output cpr_pkg::t_out       o_result
);
    import cpr_pkg::*;

    logic    r_v0, r_v1, r_v2, r_v3, r_v4;
    t_in     r_in;
    t_side_a r_a1, r_a2, r_a3;
    t_side_a n_a1, n_a3;
    logic [65:0] r_sqx, r_sqy, r_ss, r_d2;
    logic [65:0] n_d2;

    t_side_a r_da [0:SQ_STEPS-1];
    logic    sq_valid;
    logic [SQ_STEPS-1:0] sq_root;

    t_side_b r_b;
    t_side_b n_b;
    logic [DIV_NUM_W-1:0] r_num_x, r_num_y, r_num_a, r_num_b;
    logic [DIV_DEN_W-1:0] r_dist, r_msum;
    logic signed [35:0]   ov2;
    t_side_b r_db [0:DIV_Q_W-1];

    logic               dv_x, dv_y, dv_a, dv_b;
    logic [DIV_Q_W-1:0] q_x, q_y, q_a, q_b;
    t_imp               imp_in;
    t_side_b            sb;
    t_side_a            sa_last;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v0 <= start;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= sq_valid;
        end
    end

    always_comb begin
        logic signed [32:0] dx, dy;
        dx          = $signed({r_in.b_pos_x[31], r_in.b_pos_x})
                    - $signed({r_in.a_pos_x[31], r_in.a_pos_x});
        dy          = $signed({r_in.b_pos_y[31], r_in.b_pos_y})
                    - $signed({r_in.a_pos_y[31], r_in.a_pos_y});
        n_a1        = '0;
        n_a1.orig   = r_in;
        n_a1.sx     = dx[32];
        n_a1.sy     = dy[32];
        n_a1.mdx    = dx[32] ? 33'(-dx) : 33'(dx);
        n_a1.mdy    = dy[32] ? 33'(-dy) : 33'(dy);
        n_a1.s      = {1'b0, r_in.a_diameter} + {1'b0, r_in.b_diameter};
        n_a1.rvx    = $signed({r_in.b_vel_x[31], r_in.b_vel_x})
                    - $signed({r_in.a_vel_x[31], r_in.a_vel_x});
        n_a1.rvy    = $signed({r_in.b_vel_y[31], r_in.b_vel_y})
                    - $signed({r_in.a_vel_y[31], r_in.a_vel_y});
        n_a1.msum   = {1'b0, r_in.a_mass} + {1'b0, r_in.b_mass};
        n_a1.wnum_a = ({32'b0, r_in.b_mass} << 30) + {32'b0, n_a1.msum[32:1]};
        n_a1.wnum_b = ({32'b0, r_in.a_mass} << 30) + {32'b0, n_a1.msum[32:1]};
    end

    always_comb begin
        n_d2     = r_sqx + r_sqy;
        n_a3     = r_a2;
        n_a3.hit = ({2'b00, r_ss} > {n_d2, 2'b00});
        n_a3.nz  = (n_d2 != '0);
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_in <= i_item;
        end
        r_a1  <= n_a1;
        r_a2  <= r_a1;
        r_sqx <= 66'(r_a1.mdx) * 66'(r_a1.mdx);
        r_sqy <= 66'(r_a1.mdy) * 66'(r_a1.mdy);
        r_ss  <= 66'(r_a1.s) * 66'(r_a1.s);
        r_a3  <= n_a3;
        r_d2  <= n_d2;
        r_da[0] <= r_a3;
        for (int i = 1; i < SQ_STEPS; i++) begin
            r_da[i] <= r_da[i-1];
        end
    end

    cpr_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v3),
        .i_rad   ({2'b00, r_d2}),
        .o_valid (sq_valid),
        .o_root  (sq_root)
    );

    assign sa_last = r_da[SQ_STEPS-1];

    always_comb begin
        ov2        = $signed({3'b000, sa_last.s}) - $signed({1'b0, sq_root, 1'b0});
        n_b.orig   = sa_last.orig;
        n_b.sx     = sa_last.sx;
        n_b.sy     = sa_last.sy;
        n_b.rvx    = sa_last.rvx;
        n_b.rvy    = sa_last.rvy;
        n_b.msum_z = (sa_last.msum == '0);
        n_b.hit    = sa_last.hit;
        n_b.ok     = sa_last.hit && sa_last.nz;
        n_b.ovp    = (n_b.ok && !ov2[35] && (ov2 != '0)) ? ov2[33:0] : '0;
    end

    always_ff @(posedge i_clk) begin
        r_b     <= n_b;
        r_num_x <= ({31'b0, sa_last.mdx} << 30) + {31'b0, sq_root[SQ_STEPS-1:1]};
        r_num_y <= ({31'b0, sa_last.mdy} << 30) + {31'b0, sq_root[SQ_STEPS-1:1]};
        r_num_a <= sa_last.wnum_a;
        r_num_b <= sa_last.wnum_b;
        r_dist  <= sq_root;
        r_msum  <= {1'b0, sa_last.msum};
        r_db[0] <= r_b;
        for (int i = 1; i < DIV_Q_W; i++) begin
            r_db[i] <= r_db[i-1];
        end
    end

    cpr_div u_div_x (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_valid (r_v4),
        .i_num (r_num_x), .i_den (r_dist), .o_valid (dv_x), .o_quot (q_x)
    );

    cpr_div u_div_y (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_valid (r_v4),
        .i_num (r_num_y), .i_den (r_dist), .o_valid (dv_y), .o_quot (q_y)
    );

    cpr_div u_div_a (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_valid (r_v4),
        .i_num (r_num_a), .i_den (r_msum), .o_valid (dv_a), .o_quot (q_a)
    );

    cpr_div u_div_b (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_valid (r_v4),
        .i_num (r_num_b), .i_den (r_msum), .o_valid (dv_b), .o_quot (q_b)
    );

    // The side line is as long as the divider, since r_b is loaded in the
    // same cycle as the divider inputs.
    always_comb begin
        logic signed [31:0] ux, uy;
        sb          = r_db[DIV_Q_W-1];
        ux          = $signed({1'b0, q_x});
        uy          = $signed({1'b0, q_y});
        imp_in.orig = sb.orig;
        imp_in.hit  = sb.hit;
        imp_in.ok   = sb.ok;
        imp_in.ovp  = sb.ovp;
        imp_in.rvx  = sb.rvx;
        imp_in.rvy  = sb.rvy;
        imp_in.nx   = sb.sx ? -ux : ux;
        imp_in.ny   = sb.sy ? -uy : uy;
        imp_in.wa   = sb.msum_z ? '0 : q_a;
        imp_in.wb   = sb.msum_z ? '0 : q_b;
    end

    cpr_impulse u_impulse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (dv_x && dv_y && dv_a && dv_b),
        .i_imp    (imp_in),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/cpr_sqrt.sv =====
`default_nettype none

module cpr_sqrt (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    input  wire logic [cpr_pkg::SQ_IN_W-1:0]  i_rad,
    output logic                              o_valid,
    output logic [cpr_pkg::SQ_STEPS-1:0]      o_root
);
    import cpr_pkg::*;

    logic                 r_v    [0:SQ_STEPS-1];
    logic [SQ_REM_W-1:0]  r_rem  [0:SQ_STEPS-1];
    logic [SQ_STEPS-1:0]  r_root [0:SQ_STEPS-1];
    logic [SQ_IN_W-1:0]   r_rad  [0:SQ_STEPS-1];

    genvar gk;
    for (gk = 0; gk < SQ_STEPS; gk++) begin : g_st
        logic                src_v;
        logic [SQ_REM_W-1:0] src_rem;
        logic [SQ_STEPS-1:0] src_root;
        logic [SQ_IN_W-1:0]  src_rad;
        logic [SQ_REM_W+1:0] rem_t;
        logic [SQ_REM_W+1:0] trial;
        logic                ge;
        logic [SQ_REM_W+1:0] diff;

        if (gk == 0) begin : g_first
            assign src_v    = i_valid;
            assign src_rem  = '0;
            assign src_root = '0;
            assign src_rad  = i_rad;
        end else begin : g_next
            assign src_v    = r_v[gk-1];
            assign src_rem  = r_rem[gk-1];
            assign src_root = r_root[gk-1];
            assign src_rad  = r_rad[gk-1];
        end

        always_comb begin
            rem_t = {src_rem, src_rad[SQ_IN_W-1 -: 2]};
            trial = {2'b00, src_root, 2'b01};
            ge    = (rem_t >= trial);
            diff  = rem_t - trial;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[gk] <= 1'b0;
            end else begin
                r_v[gk] <= src_v;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[gk]  <= ge ? diff[SQ_REM_W-1:0] : rem_t[SQ_REM_W-1:0];
            r_root[gk] <= {src_root[SQ_STEPS-2:0], ge};
            r_rad[gk]  <= {src_rad[SQ_IN_W-3:0], 2'b00};
        end
    end

    assign o_valid = r_v[SQ_STEPS-1];
    assign o_root  = r_root[SQ_STEPS-1];

endmodule

`default_nettype wire

// ===== hw/rtl/cpr_div.sv =====
`default_nettype none

module cpr_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    input  wire logic [cpr_pkg::DIV_NUM_W-1:0] i_num,
    input  wire logic [cpr_pkg::DIV_DEN_W-1:0] i_den,
    output logic                               o_valid,
    output logic [cpr_pkg::DIV_Q_W-1:0]        o_quot
);
    import cpr_pkg::*;

    logic                 r_v   [0:DIV_Q_W-1];
    logic [DIV_REM_W-1:0] r_rem [0:DIV_Q_W-1];
    logic [DIV_Q_W-1:0]   r_low [0:DIV_Q_W-1];
    logic [DIV_DEN_W-1:0] r_den [0:DIV_Q_W-1];
    logic [DIV_Q_W-1:0]   r_q   [0:DIV_Q_W-1];

    genvar gk;
    for (gk = 0; gk < DIV_Q_W; gk++) begin : g_st
        logic                 src_v;
        logic [DIV_REM_W-1:0] src_rem;
        logic [DIV_Q_W-1:0]   src_low;
        logic [DIV_DEN_W-1:0] src_den;
        logic [DIV_Q_W-1:0]   src_q;
        logic [DIV_REM_W:0]   rem_t;
        logic [DIV_REM_W:0]   diff;
        logic                 ge;

        if (gk == 0) begin : g_first
            assign src_v   = i_valid;
            assign src_rem = DIV_REM_W'(i_num[DIV_NUM_W-1:DIV_Q_W]);
            assign src_low = i_num[DIV_Q_W-1:0];
            assign src_den = i_den;
            assign src_q   = '0;
        end else begin : g_next
            assign src_v   = r_v[gk-1];
            assign src_rem = r_rem[gk-1];
            assign src_low = r_low[gk-1];
            assign src_den = r_den[gk-1];
            assign src_q   = r_q[gk-1];
        end

        always_comb begin
            rem_t = {src_rem, src_low[DIV_Q_W-1-gk]};
            ge    = (rem_t >= {1'b0, src_den});
            diff  = rem_t - {1'b0, src_den};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[gk] <= 1'b0;
            end else begin
                r_v[gk] <= src_v;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[gk] <= ge ? diff[DIV_REM_W-1:0] : rem_t[DIV_REM_W-1:0];
            r_low[gk] <= src_low;
            r_den[gk] <= src_den;
            r_q[gk]   <= {src_q[DIV_Q_W-2:0], ge};
        end
    end

    assign o_valid = r_v[DIV_Q_W-1];
    assign o_quot  = r_q[DIV_Q_W-1];

endmodule

`default_nettype wire

// ===== hw/rtl/cpr_impulse.sv =====
`default_nettype none

module cpr_impulse (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire cpr_pkg::t_imp  i_imp,
    output logic                o_valid,
    output cpr_pkg::t_out       o_result
);
    import cpr_pkg::*;

    logic                r_v [0:IMP_STAGES-1];
    t_ctx                r_c [0:IMP_STAGES-1];
    t_ctx                c_in;

    logic signed [PW-1:0] r_p1_sa, r_p1_sb, r_p1_vx, r_p1_vy;
    logic signed [XW-1:0] r_sa, r_sb, r_vn;
    logic signed [PW-1:0] r_p2_ax, r_p2_ay, r_p2_bx, r_p2_by, r_p2_j;
    t_out                 r_po3, r_po4, r_po5, r_po6;
    logic signed [XW-1:0] r_j;
    logic signed [PW-1:0] r_p3_ja, r_p3_jb;
    logic signed [XW-1:0] r_ja, r_jb;
    logic signed [PW-1:0] r_p4_ax, r_p4_ay, r_p4_bx, r_p4_by;
    t_out                 r_out;
    t_ctx                 n_c2;
    t_out                 n_po3;

    always_comb begin
        c_in.orig = i_imp.orig;
        c_in.hit  = i_imp.hit;
        c_in.imp  = i_imp.ok;
        c_in.nx   = i_imp.nx;
        c_in.ny   = i_imp.ny;
        c_in.wa   = i_imp.wa;
        c_in.wb   = i_imp.wb;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < IMP_STAGES; i++) begin
                r_v[i] <= 1'b0;
            end
        end else begin
            r_v[0] <= i_valid;
            for (int i = 1; i < IMP_STAGES; i++) begin
                r_v[i] <= r_v[i-1];
            end
        end
    end

    always_comb begin
        n_c2     = r_c[1];
        n_c2.imp = r_c[1].imp && (r_vn[XW-1] || (r_vn == '0));
    end

    always_comb begin
        n_po3                 = '0;
        n_po3.new_a_pos_x     = sat32(XW'(r_c[2].orig.a_pos_x) - rshr(r_p2_ax, 30));
        n_po3.new_a_pos_y     = sat32(XW'(r_c[2].orig.a_pos_y) - rshr(r_p2_ay, 30));
        n_po3.new_b_pos_x     = sat32(XW'(r_c[2].orig.b_pos_x) + rshr(r_p2_bx, 30));
        n_po3.new_b_pos_y     = sat32(XW'(r_c[2].orig.b_pos_y) + rshr(r_p2_by, 30));
        n_po3.hit             = r_c[2].hit;
        n_po3.impulse_applied = r_c[2].imp;
    end

    always_ff @(posedge i_clk) begin
        r_c[0]  <= c_in;
        r_p1_sa <= smul(XW'(i_imp.ovp), $signed({1'b0, i_imp.wa}));
        r_p1_sb <= smul(XW'(i_imp.ovp), $signed({1'b0, i_imp.wb}));
        r_p1_vx <= smul(XW'(i_imp.rvx), i_imp.nx);
        r_p1_vy <= smul(XW'(i_imp.rvy), i_imp.ny);

        r_c[1] <= r_c[0];
        r_sa   <= rshr(r_p1_sa, 31);
        r_sb   <= rshr(r_p1_sb, 31);
        r_vn   <= rshr(r_p1_vx, 30) + rshr(r_p1_vy, 30);

        r_c[2]  <= n_c2;
        r_p2_ax <= smul(r_sa, r_c[1].nx);
        r_p2_ay <= smul(r_sa, r_c[1].ny);
        r_p2_bx <= smul(r_sb, r_c[1].nx);
        r_p2_by <= smul(r_sb, r_c[1].ny);
        r_p2_j  <= smul(r_vn, ONE_PLUS_E_Q30);

        r_c[3] <= r_c[2];
        r_po3  <= n_po3;
        r_j    <= r_c[2].imp ? rshr(r_p2_j, 30) : '0;

        r_c[4]  <= r_c[3];
        r_po4   <= r_po3;
        r_p3_ja <= smul(r_j, $signed({1'b0, r_c[3].wa}));
        r_p3_jb <= smul(r_j, $signed({1'b0, r_c[3].wb}));

        r_c[5] <= r_c[4];
        r_po5  <= r_po4;
        r_ja   <= rshr(r_p3_ja, 30);
        r_jb   <= rshr(r_p3_jb, 30);

        r_c[6]  <= r_c[5];
        r_po6   <= r_po5;
        r_p4_ax <= smul(r_ja, r_c[5].nx);
        r_p4_ay <= smul(r_ja, r_c[5].ny);
        r_p4_bx <= smul(r_jb, r_c[5].nx);
        r_p4_by <= smul(r_jb, r_c[5].ny);

        r_c[7] <= r_c[6];
        r_out  <= '{
            new_a_pos_x:     r_po6.new_a_pos_x,
            new_a_pos_y:     r_po6.new_a_pos_y,
            new_a_vel_x:     sat32(XW'(r_c[6].orig.a_vel_x) + rshr(r_p4_ax, 30)),
            new_a_vel_y:     sat32(XW'(r_c[6].orig.a_vel_y) + rshr(r_p4_ay, 30)),
            new_b_pos_x:     r_po6.new_b_pos_x,
            new_b_pos_y:     r_po6.new_b_pos_y,
            new_b_vel_x:     sat32(XW'(r_c[6].orig.b_vel_x) - rshr(r_p4_bx, 30)),
            new_b_vel_y:     sat32(XW'(r_c[6].orig.b_vel_y) - rshr(r_p4_by, 30)),
            hit:             r_po6.hit,
            impulse_applied: r_po6.impulse_applied
        };
    end

    assign o_valid  = r_v[IMP_STAGES-1];
    assign o_result = r_out;

    a_imp_needs_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_result.hit |-> !o_result.impulse_applied)
        else $error("impulse flagged without a hit");

    a_miss_passes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_result.hit |->
            o_result.new_a_vel_x == r_c[7].orig.a_vel_x &&
            o_result.new_b_pos_y == r_c[7].orig.b_pos_y)
        else $error("bodies changed without a hit");

    a_flags_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_result.impulse_applied == r_c[7].imp && o_result.hit == r_c[7].hit)
        else $error("flags lost alignment with their item");

    a_reset_clears: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("result strobe after reset");

endmodule

`default_nettype wire

// ===== verif/circle_pair_collision_resolver_test.sv =====
`timescale 1ns / 1ps

module circle_pair_collision_resolver_test;
    import cpr_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 120;
    localparam longint RESTITUTION_Q30 = 64'sd1717986918;

    logic i_clk;
    logic i_rst_n;
    logic start;
    t_in  i_item;
    logic busy;
    logic o_valid;
    t_out o_result;

    t_in  pending_pairs[$];
    t_out expected_bodies[$];
    bit   took;
    bit   failed;
    bit   no_gaps;
    int   gap_left;
    int   idle_cycles;

    circle_pair_collision_resolver dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic queue_pair(input t_in p);
        pending_pairs = {pending_pairs, p};
    endtask

    function automatic logic [63:0] magnitude(input longint v);
        return v < 0 ? 64'd0 - 64'(v) : 64'(v);
    endfunction

    function automatic longint mul_round(input longint a, input longint b, input int k);
        logic [127:0] p;
        logic [62:0]  r;
        p = 128'(magnitude(a)) * 128'(magnitude(b)) + (128'd1 << (k - 1));
        r = 63'(p >> k);
        return ((a < 0) != (b < 0)) ? -longint'({1'b0, r}) : longint'({1'b0, r});
    endfunction

    function automatic longint unit_component(input longint d, input logic [63:0] dist_len);
        logic [127:0] q;
        q = ((128'(magnitude(d)) << 30) + 128'(dist_len / 2)) / 128'(dist_len);
        return d < 0 ? -longint'(q) : longint'(q);
    endfunction

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return 32'(v);
    endfunction

    function automatic t_out resolve_pair(input t_in p);
        longint apx, apy, avx, avy, bpx, bpy, bvx, bvy, dx, dy;
        longint nx, ny, wa, wb, ov2, sa, sb, vn, j, ja, jb;
        logic [63:0]  s, msum, root_dist, c;
        logic [127:0] d2, ss;
        logic hit, imp;
        t_out r;
        apx = p.a_pos_x; apy = p.a_pos_y; avx = p.a_vel_x; avy = p.a_vel_y;
        bpx = p.b_pos_x; bpy = p.b_pos_y; bvx = p.b_vel_x; bvy = p.b_vel_y;
        dx = bpx - apx;
        dy = bpy - apy;
        s = 64'(p.a_diameter) + 64'(p.b_diameter);
        d2 = 128'(magnitude(dx)) * 128'(magnitude(dx)) + 128'(magnitude(dy)) * 128'(magnitude(dy));
        ss = 128'(s) * 128'(s);
        hit = ss > (d2 << 2);
        imp = 1'b0;
        if (hit && d2 != 0) begin
            root_dist = 0;
            for (int b = 33; b >= 0; b--) begin
                c = root_dist | (64'd1 << b);
                if (128'(c) * 128'(c) <= d2) root_dist = c;
            end
            nx = unit_component(dx, root_dist);
            ny = unit_component(dy, root_dist);
            msum = 64'(p.a_mass) + 64'(p.b_mass);
            wa = 0;
            wb = 0;
            if (msum != 0) begin
                wa = longint'(((64'(p.b_mass) << 30) + msum / 2) / msum);
                wb = longint'(((64'(p.a_mass) << 30) + msum / 2) / msum);
            end
            ov2 = longint'(s) - 2 * longint'(root_dist);
            if (ov2 > 0) begin
                sa = mul_round(ov2, wa, 31);
                sb = mul_round(ov2, wb, 31);
                apx -= mul_round(sa, nx, 30);
                apy -= mul_round(sa, ny, 30);
                bpx += mul_round(sb, nx, 30);
                bpy += mul_round(sb, ny, 30);
            end
            vn = mul_round(bvx - avx, nx, 30) + mul_round(bvy - avy, ny, 30);
            if (vn <= 0) begin
                j = mul_round(vn, RESTITUTION_Q30, 30);
                ja = mul_round(j, wa, 30);
                jb = mul_round(j, wb, 30);
                avx += mul_round(ja, nx, 30);
                avy += mul_round(ja, ny, 30);
                bvx -= mul_round(jb, nx, 30);
                bvy -= mul_round(jb, ny, 30);
                imp = 1'b1;
            end
        end
        r.new_a_pos_x = clamp32(apx);
        r.new_a_pos_y = clamp32(apy);
        r.new_a_vel_x = clamp32(avx);
        r.new_a_vel_y = clamp32(avy);
        r.new_b_pos_x = clamp32(bpx);
        r.new_b_pos_y = clamp32(bpy);
        r.new_b_vel_x = clamp32(bvx);
        r.new_b_vel_y = clamp32(bvy);
        r.hit = hit;
        r.impulse_applied = imp;
        return r;
    endfunction

    function automatic t_in make_pair(input int ax, input int ay, input int avx, input int avy,
                                      input int bx, input int by, input int bvx, input int bvy,
                                      input logic [31:0] ad, input logic [31:0] bd,
                                      input logic [31:0] am, input logic [31:0] bm);
        t_in p;
        p.a_pos_x = ax; p.a_pos_y = ay; p.a_vel_x = avx; p.a_vel_y = avy;
        p.b_pos_x = bx; p.b_pos_y = by; p.b_vel_x = bvx; p.b_vel_y = bvy;
        p.a_diameter = ad; p.b_diameter = bd; p.a_mass = am; p.b_mass = bm;
        return p;
    endfunction

    function automatic int near_offset(input int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic t_in random_pair();
        t_in p;
        int span;
        p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        if ($urandom_range(0, 9) < 8) begin
            span = 1 << $urandom_range(4, 24);
            p.b_pos_x = p.a_pos_x + near_offset(span);
            p.b_pos_y = p.a_pos_y + near_offset(span);
            p.a_diameter = $urandom_range(0, 4 * span);
            p.b_diameter = $urandom_range(0, 4 * span);
            if ($urandom_range(0, 1)) begin
                p.a_vel_x = near_offset(1 << 22);
                p.a_vel_y = near_offset(1 << 22);
                p.b_vel_x = near_offset(1 << 22);
                p.b_vel_y = near_offset(1 << 22);
            end
            case ($urandom_range(0, 7))
                0: p.a_mass = 0;
                1: p.b_mass = 0;
                2: begin
                    p.a_mass = 0;
                    p.b_mass = 0;
                end
                3: p.b_mass = p.a_mass;
                default: ;
            endcase
        end
        return p;
    endfunction

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n) begin
            idle_cycles = idle_cycles + 1;
            if (start && !busy) begin
                expected_bodies = {expected_bodies, resolve_pair(i_item)};
                took = 1'b1;
                idle_cycles = 0;
            end
            if (o_valid) begin
                idle_cycles = 0;
                if (expected_bodies.size() == 0) begin
                    $display("%0t: result with nothing expected, actual %p", $time, o_result);
                    failed = 1'b1;
                end else begin
                    want = expected_bodies.pop_front();
                    if (o_result !== want) begin
                        $display("%0t: mismatch, expected %p, actual %p", $time, want, o_result);
                        failed = 1'b1;
                    end
                end
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("circle_pair_collision_resolver_test: FAIL");
                $finish;
            end
        end
    end

    always @(negedge i_clk) begin
        logic nxt_start;
        nxt_start = start;
        if (i_rst_n && !(start && !took)) begin
            took = 1'b0;
            nxt_start = 1'b0;
            if (gap_left > 0) begin
                gap_left = gap_left - 1;
            end else if (pending_pairs.size() > 0) begin
                i_item <= pending_pairs.pop_front();
                nxt_start = 1'b1;
                if ($urandom_range(0, 63) == 0) no_gaps = ~no_gaps;
                gap_left = no_gaps ? 0 : $urandom_range(0, 7);
            end
        end
        start <= nxt_start;
    end

    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        i_item = '0;
        took = 1'b0;
        failed = 1'b0;
        no_gaps = 1'b0;
        gap_left = 0;
        idle_cycles = 0;

        // No hit, coincident centers, separating, approaching.
        queue_pair(make_pair(0, 0, 0, 0, 32'h0010_0000, 0, 0, 0,
                             32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
        queue_pair(make_pair(100, 200, 5, 6, 100, 200, 7, 8,
                             32'h0002_0000, 32'h0002_0000, 32'h0001_0000, 32'h0001_0000));
        queue_pair(make_pair(0, 0, -32'h0001_0000, 0, 32'h0001_0000, 0, 32'h0001_0000, 0,
                             32'h0002_0000, 32'h0002_0000, 32'h0001_0000, 32'h0002_0000));
        queue_pair(make_pair(0, 0, 32'h0001_0000, 0, 32'h0001_0000, 0, -32'h0001_0000, 0,
                             32'h0002_0000, 32'h0002_0000, 32'h0001_0000, 32'h0002_0000));
        queue_pair(make_pair(0, 0, 0, 32'h0001_0000, 32'h0000_8000, 32'h0000_8000, 0, 0,
                             32'h0002_0000, 32'h0001_0000, 32'h0003_0000, 32'h0001_0000));
        // Zero masses, one zero mass each way.
        queue_pair(make_pair(0, 0, 32'h0001_0000, 0, 32'h0001_0000, 0, 0, 0,
                             32'h0002_0000, 32'h0002_0000, 0, 0));
        queue_pair(make_pair(0, 0, 32'h0001_0000, 0, 32'h0001_0000, 0, 0, 0,
                             32'h0002_0000, 32'h0002_0000, 0, 32'h0001_0000));
        queue_pair(make_pair(0, 0, 32'h0001_0000, 0, 32'h0001_0000, 0, 0, 0,
                             32'h0002_0000, 32'h0002_0000, 32'h0001_0000, 0));
        // Field extremes and saturation.
        queue_pair(make_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                             32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                             32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff));
        queue_pair(make_pair(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                             32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                             32'hffff_ffff, 32'hffff_ffff, 1, 32'hffff_ffff));
        queue_pair(make_pair(32'h7fff_fff0, 0, 32'h7fff_ffff, 0, 32'h7fff_ffff, 0,
                             32'h8000_0000, 0, 32'hffff_ffff, 32'hffff_ffff, 1, 1));
        queue_pair(make_pair(0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 1, 1));
        queue_pair(make_pair(0, 0, 0, 0, 1, 0, 0, 0, 0, 3, 1, 1));
        queue_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1));
        queue_pair(t_in'('1));
        queue_pair(t_in'('0));
        queue_pair(make_pair(-5, -5, 3, -3, 5, 5, -3, 3, 40, 40, 32'hffff_ffff, 1));
        for (int n = 0; n < 1850; n++) queue_pair(random_pair());

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        wait (pending_pairs.size() == 0 && !start && expected_bodies.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (!failed && expected_bodies.size() == 0) begin
            $display("circle_pair_collision_resolver_test: PASS");
        end else begin
            $display("circle_pair_collision_resolver_test: FAIL");
        end
        $finish;
    end
endmodule

// ===== circle_pair_collision_resolver.f =====
hw/rtl/cpr_pkg.sv
hw/rtl/cpr_sqrt.sv
hw/rtl/cpr_div.sv
hw/rtl/cpr_impulse.sv
hw/rtl/circle_pair_collision_resolver.sv
verif/circle_pair_collision_resolver_test.sv
